// File: hw/rtl/pem_pkg.sv
// shared types and constants for the prewitt edge magnitude core
`timescale 1ns / 1ps
package pem_pkg;

  localparam int CFG_W          = 11;
  localparam int MAG_W          = 11;
  localparam int CFG_IDX_W      = 4;
  localparam int MIN_DIM        = 3;
  localparam int WIDTH_RST      = 24;
  localparam int HEIGHT_RST     = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int OUT_DEPTH      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } pem_ctl_t;

  typedef struct packed {
    logic             last;
    logic [MAG_W-1:0] magnitude;
  } pem_res_t;

endpackage

// File: hw/rtl/prewitt_edge_magnitude_core.sv
// top level of the 3x3 prewitt edge magnitude core
`timescale 1ns / 1ps
// Pixels enter in raster order on in_pixel, one word per cycle while in_stall
// is low, with in_frame_start marking the first pixel of a frame. Once a full
// 3x3 window is present (row >= 2 and column >= 2) one word leaves on
// out_magnitude holding |gx|+|gy| of the window ending at that pixel; out_last
// flags the frame's final window. Border positions produce no word.
// Image size is set over the cfg port (index 0 width, index 1 height). The user
// must write it only while the core is idle; the core does not enforce this.
// cfg_ready is always high. A pixel accepted on the in port passes the line
// store read, window update, gradient and magnitude steps, in that order.
// Throughput: one pixel per cycle while in_stall is low, set by the single
// read-modify-write pass on the two line store memories per pixel.
// The result queue holds eight words; in_stall rises once the queued words plus
// those still in the pipeline reach eight, so a stalled receiver backs the
// core up without loss. Reset clears counters, window and queue and restores
// width 24 and height 7; the line stores are not cleared.
module prewitt_edge_magnitude_core #(
  parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pem_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = pem_pkg::DEF_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PIXEL_BITS-1:0]         in_pixel,
  input  logic                          in_frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pem_pkg::MAG_W-1:0]     out_magnitude,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pem_pkg::CFG_W-1:0]     cfg_data
);
  import pem_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int QCW = $clog2(OUT_DEPTH + 1);

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic [WW-1:0]    w_sat;
  logic [HW-1:0]    h_sat;
  logic [CW-1:0]    col_r, col_nxt, c0;
  logic [RW-1:0]    row_r, row_nxt, r0;
  logic             accept;
  pem_ctl_t         ctl;
  logic             res_valid;
  pem_res_t         res, head;
  logic [1:0]       pend;
  logic [QCW-1:0]   q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(WIDTH_RST);
      cfg_height_r <= CFG_W'(HEIGHT_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r < CFG_W'(MIN_DIM)) begin
      w_sat = WW'(MIN_DIM);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(cfg_width_r);
    end
    if (cfg_height_r < CFG_W'(MIN_DIM)) begin
      h_sat = HW'(MIN_DIM);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(cfg_height_r);
    end
  end

  // hold off while the queue plus in-flight words could overflow
  assign in_stall = ((QCW + 1)'(q_count) + (QCW + 1)'(pend)) >= (QCW + 1)'(OUT_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    c0 = in_frame_start ? '0 : col_r;
    r0 = in_frame_start ? '0 : row_r;
    ctl.valid = accept;
    ctl.emit  = (32'(r0) >= 32'd2) && (32'(c0) >= 32'd2);
    ctl.last  = (HW'(r0) == HW'(h_sat - 1'b1)) && (WW'(c0) == WW'(w_sat - 1'b1));
    if (WW'(WW'(c0) + 1'b1) >= w_sat) begin
      col_nxt = '0;
      row_nxt = (HW'(HW'(r0) + 1'b1) >= h_sat) ? '0 : RW'(r0 + 1'b1);
    end else begin
      col_nxt = CW'(c0 + 1'b1);
      row_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  pem_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl),
    .pixel_i     (in_pixel),
    .addr_i      (c0),
    .res_valid_o (res_valid),
    .res_o       (res),
    .pend_o      (pend)
  );

  pem_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_valid),
    .din_i   (res),
    .stall_i (out_stall),
    .valid_o (out_valid),
    .dout_o  (head),
    .count_o (q_count)
  );

  assign out_magnitude = head.magnitude;
  assign out_last      = head.last;

endmodule

// File: hw/rtl/pem_window.sv
// line stores, 3x3 window and prewitt gradient pipeline
`timescale 1ns / 1ps
module pem_window #(
  parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = pem_pkg::DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pem_pkg::pem_ctl_t            ctl_i,
  input  logic [PIXEL_BITS-1:0]        pixel_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  output logic                         res_valid_o,
  output pem_pkg::pem_res_t            res_o,
  output logic [1:0]                   pend_o
);
  import pem_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int SW   = PIXEL_BITS + 2;
  localparam int GW   = PIXEL_BITS + 3;
  localparam int FULW = (GW > MAG_W) ? GW : MAG_W;

  logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];

  logic                  s1_v_r, s1_emit_r, s1_last_r;
  logic [AW-1:0]         s1_addr_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [PIXEL_BITS-1:0] rd_a_r, rd_b_r;
  logic                  fwd_r;
  logic [PIXEL_BITS-1:0] fwd_a_r, fwd_b_r;
  logic [PIXEL_BITS-1:0] up1, up2;

  logic [PIXEL_BITS-1:0] win_r [3][3];

  logic                  s2_v_r, s2_last_r;
  logic                  s3_v_r, s3_last_r;
  logic signed [GW-1:0]  gx_r, gy_r;
  logic signed [GW-1:0]  gx, gy;
  logic [SW-1:0]         col0, col2, row0, row2;
  logic [SW-1:0]         ax, ay;
  logic [FULW-1:0]       mag_full;

  // previous write may hit the entry read in the same cycle
  assign up1 = fwd_r ? fwd_a_r : rd_a_r;
  assign up2 = fwd_r ? fwd_b_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (ctl_i.valid) begin
      rd_a_r  <= mem_a[addr_i];
      rd_b_r  <= mem_b[addr_i];
      fwd_a_r <= s1_px_r;
      fwd_b_r <= up1;
      s1_addr_r <= addr_i;
      s1_px_r   <= pixel_i;
    end
    if (s1_v_r) begin
      mem_a[s1_addr_r] <= s1_px_r;
      mem_b[s1_addr_r] <= up1;
    end
    if (s2_v_r) begin
      gx_r <= gx;
      gy_r <= gy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s1_last_r <= 1'b0;
      fwd_r     <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
      s3_v_r    <= 1'b0;
      s3_last_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      s1_v_r <= ctl_i.valid;
      if (ctl_i.valid) begin
        s1_emit_r <= ctl_i.emit;
        s1_last_r <= ctl_i.last;
        fwd_r     <= s1_v_r && (addr_i == s1_addr_r);
      end
      if (s1_v_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k][0] <= win_r[k][1];
          win_r[k][1] <= win_r[k][2];
        end
        win_r[0][2] <= up2;
        win_r[1][2] <= up1;
        win_r[2][2] <= s1_px_r;
      end
      s2_v_r    <= s1_v_r && s1_emit_r;
      s2_last_r <= s1_last_r;
      s3_v_r    <= s2_v_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_comb begin
    col0 = SW'(win_r[0][0]) + SW'(win_r[1][0]) + SW'(win_r[2][0]);
    col2 = SW'(win_r[0][2]) + SW'(win_r[1][2]) + SW'(win_r[2][2]);
    row0 = SW'(win_r[0][0]) + SW'(win_r[0][1]) + SW'(win_r[0][2]);
    row2 = SW'(win_r[2][0]) + SW'(win_r[2][1]) + SW'(win_r[2][2]);
    gx   = signed'({1'b0, col0}) - signed'({1'b0, col2});
    gy   = signed'({1'b0, row2}) - signed'({1'b0, row0});
  end

  always_comb begin
    ax       = gx_r[GW-1] ? SW'(-gx_r) : SW'(gx_r);
    ay       = gy_r[GW-1] ? SW'(-gy_r) : SW'(gy_r);
    mag_full = FULW'(ax) + FULW'(ay);
  end

  assign res_valid_o     = s3_v_r;
  assign res_o.magnitude = mag_full[MAG_W-1:0];
  assign res_o.last      = s3_last_r;
  assign pend_o = 2'(s1_v_r && s1_emit_r) + 2'(s2_v_r) + 2'(s3_v_r);

endmodule

// File: hw/rtl/pem_out_fifo.sv
// result queue that decouples the pipeline from a stalling receiver
`timescale 1ns / 1ps
module pem_out_fifo (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push_i,
  input  pem_pkg::pem_res_t                     din_i,
  input  logic                                  stall_i,
  output logic                                  valid_o,
  output pem_pkg::pem_res_t                     dout_o,
  output logic [$clog2(pem_pkg::OUT_DEPTH+1)-1:0] count_o
);
  import pem_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  pem_res_t       buf_r [OUT_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           pop;

  assign valid_o = (count_r != '0);
  assign dout_o  = buf_r[rd_ptr_r];
  assign count_o = count_r;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk) begin
    if (push_i) begin
      buf_r[wr_ptr_r] <= din_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= PW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PW'(rd_ptr_r + 1'b1);
      end
      case ({push_i, pop})
        2'b10:   count_r <= CW'(count_r + 1'b1);
        2'b01:   count_r <= CW'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: dv/tb_prewitt_edge_magnitude_core.sv
// self-checking testbench for the prewitt edge magnitude core
`timescale 1ns / 1ps
module tb_prewitt_edge_magnitude_core;
  import pem_pkg::*;

  localparam int PIX_W       = DEF_PIXEL_BITS;
  localparam int MAX_W       = DEF_MAX_WIDTH;
  localparam int MAX_H       = DEF_MAX_HEIGHT;
  localparam int PIX_MAX     = (1 << PIX_W) - 1;
  localparam int CFG_MAX     = (1 << CFG_W) - 1;
  localparam int IDX_MAX     = (1 << CFG_IDX_W) - 1;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_PAUSE = 12;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

  typedef enum {ROW_CFG, ROW_PIX} row_kind_t;

  // cfg rows: a = index, b = data; pixel rows: a = pixel, b = frame start
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    bit        chk;
    int        mag;
    bit        lst;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 in_frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MAG_W-1:0]     out_magnitude;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // shadow of the core's state
  logic [PIX_W-1:0] row_up1 [MAX_W];
  logic [PIX_W-1:0] row_up2 [MAX_W];
  logic [PIX_W-1:0] win [3][3];
  logic [CFG_W-1:0] width_q = CFG_W'(WIDTH_RST);
  logic [CFG_W-1:0] height_q = CFG_W'(HEIGHT_RST);
  int               row_q = 0;
  int               col_q = 0;
  bit               restart_due = 1'b0;

  pem_res_t mag_due [$];
  pem_res_t want;
  dir_row_t dir_rows [$];

  int mismatches = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  always #6 clk = ~clk;

  prewitt_edge_magnitude_core #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .PIXEL_BITS(PIX_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int sat_dim(input logic [CFG_W-1:0] v, input int hi);
    if (int'(v) < MIN_DIM) return MIN_DIM;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // advance the shadow by one pixel; returns 1 when a full window completes
  function automatic bit prewitt_step(input logic [PIX_W-1:0] px, input logic fs,
                                      output pem_res_t res);
    int               w;
    int               h;
    int               r;
    int               c;
    int               idx;
    int               gx;
    int               gy;
    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    bit               hit;
    w = sat_dim(width_q, MAX_W);
    h = sat_dim(height_q, MAX_H);
    if (fs) begin
      row_q = 0;
      col_q = 0;
    end
    r = row_q;
    c = col_q;
    idx = c % MAX_W;
    up1 = row_up1[idx];
    up2 = row_up2[idx];
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;
    row_up2[idx] = up1;
    row_up1[idx] = px;
    res = '0;
    hit = (r >= 2 && c >= 2);
    if (hit) begin
      gx = 0;
      gy = 0;
      for (int k = 0; k < 3; k++) begin
        gx += int'(win[k][0]) - int'(win[k][2]);
        gy += int'(win[2][k]) - int'(win[0][k]);
      end
      res.magnitude = MAG_W'((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy));
      res.last = (r == h - 1 && c == w - 1);
    end
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
    return hit;
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel(input int style, input int level);
    int v;
    case (style)
      2: v = $urandom_range(0, 1) ? PIX_MAX : 0;
      3: begin
        v = level + int'($urandom_range(0, 15)) - 8;
        if (v < 0) v = 0;
        if (v > PIX_MAX) v = PIX_MAX;
      end
      default: v = $urandom_range(0, PIX_MAX);
    endcase
    return PIX_W'(v);
  endfunction

  task automatic add_row(input row_kind_t kind, input int a, input int b,
                         input bit chk = 1'b0, input int mag = 0, input bit lst = 1'b0);
    dir_rows.push_back('{kind, a, b, chk, mag, lst});
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                            input bit chk = 1'b0, input int mag = 0, input bit lst = 1'b0);
    pem_res_t res;
    bit       hit;
    logic     fs_eff;
    fs_eff = fs | restart_due;
    restart_due = 1'b0;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs_eff;
    do @(posedge clk); while (in_stall);
    hit = prewitt_step(px, fs_eff, res);
    if (chk) begin
      if (!hit) begin
        $error("directed pixel %0d: no window completes here", px);
        mismatches++;
      end
      mag_due.push_back('{last: lst, magnitude: MAG_W'(mag)});
    end else if (hit) begin
      mag_due.push_back(res);
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_q = data;
    else if (idx == REG_IMAGE_HEIGHT) height_q = data;
  endtask

  task automatic wait_results();
    if (mag_due.size() != 0) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (mag_due.size() != 0);
    end
  endtask

  // all words in, then let pixels that make no word clear the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mag_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_config(input int w, input int h);
    wait_idle();
    // a wider row mid-frame would read line store entries this frame never wrote
    if (sat_dim(CFG_W'(w), MAX_W) > sat_dim(width_q, MAX_W) && (row_q != 0 || col_q != 0))
      restart_due = 1'b1;
    cfg_put(REG_IMAGE_WIDTH, CFG_W'(w));
    cfg_put(REG_IMAGE_HEIGHT, CFG_W'(h));
    if ($urandom_range(0, 2) == 0)
      cfg_put(CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1, IDX_MAX)), CFG_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input int budget, input int ph);
    int frame_w;
    int frame_h;
    int sent;
    int n;
    int m;
    int kind;
    int style;
    int level;
    bit paused;
    frame_w = sat_dim(width_q, MAX_W);
    frame_h = sat_dim(height_q, MAX_H);
    sent = 0;
    paused = 1'b0;
    // run out the frame left open by the previous phase
    while (restart_due || row_q != 0 || col_q != 0) begin
      send_pixel(next_pixel(0, 0), 1'b0);
      sent++;
    end
    if (ph % 4 == 2) hold_req = 1'b1;
    while (sent < budget) begin
      if (ph % 4 == 1 && !paused && sent >= budget / 2) begin
        wait_results();
        paused = 1'b1;
      end
      kind  = $urandom_range(0, 9);
      style = $urandom_range(0, 3);
      level = $urandom_range(0, PIX_MAX);
      n = frame_w * frame_h;
      if (kind <= 6) begin
        for (int i = 0; i < n; i++) send_pixel(next_pixel(style, level), i == 0);
        sent += n;
      end else if (kind == 7) begin
        // no frame start, counters wrap on their own
        for (int i = 0; i < n; i++) send_pixel(next_pixel(style, level), 1'b0);
        sent += n;
      end else if (kind == 8) begin
        // cut short, the next frame start lands mid-frame
        m = $urandom_range(1, n - 1);
        for (int i = 0; i < m; i++) send_pixel(next_pixel(style, level), i == 0);
        sent += m;
      end else begin
        m = $urandom_range(1, 20);
        for (int i = 0; i < m; i++)
          send_pixel(next_pixel(style, level), $urandom_range(0, 7) == 0);
        sent += m;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mag_due.size() == 0) begin
        $error("word with nothing due: magnitude %0d last %0d", out_magnitude, out_last);
        mismatches++;
      end else begin
        want = mag_due.pop_front();
        if (out_magnitude !== want.magnitude) begin
          $error("magnitude: expected %0d, got %0d", want.magnitude, out_magnitude);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    out_stall <= (hold_left > 0) ||
                 (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_prewitt_edge_magnitude_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    bit prev_cfg;
    int w;
    int h;
    for (int i = 0; i < MAX_W; i++) begin
      row_up1[i] = '0;
      row_up2[i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) win[k][j] = '0;

    // smallest frame, saturated from below; unmapped index must be dropped
    add_row(ROW_CFG, REG_IMAGE_WIDTH, 0);
    add_row(ROW_CFG, REG_IMAGE_HEIGHT, 2);
    add_row(ROW_CFG, REG_UNMAPPED, CFG_MAX);
    // strongest positive response in both directions
    add_row(ROW_PIX, 0, 1);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, 0, 0, 1'b1, 1020, 1'b1);
    // strongest negative response, frame start left out
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, 0, 0);
    add_row(ROW_PIX, 0, 0, 1'b1, 1020, 1'b1);
    // stray pixel, then a frame start mid-frame; flat frame gives zero
    add_row(ROW_PIX, 17, 0);
    add_row(ROW_PIX, PIX_MAX, 1);
    for (int i = 0; i < 7; i++) add_row(ROW_PIX, PIX_MAX, 0);
    add_row(ROW_PIX, PIX_MAX, 0, 1'b1, 0, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 8;
    receiver_stall_pct = 48;
    prev_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) wait_idle();
        cfg_put(CFG_IDX_W'(dir_rows[i].a), CFG_W'(dir_rows[i].b));
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid <= 1'b0;
        prev_cfg = 1'b0;
        send_pixel(PIX_W'(dir_rows[i].a), dir_rows[i].b != 0, dir_rows[i].chk,
                   dir_rows[i].mag, dir_rows[i].lst);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin
          sender_idle_pct = 8;
          receiver_stall_pct = 48;
        end
        1: begin
          sender_idle_pct = 48;
          receiver_stall_pct = 8;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
      endcase
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, MIN_DIM - 1);
        1: w = MIN_DIM;
        default: w = $urandom_range(MIN_DIM, 24);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, MIN_DIM - 1);
        1: h = MIN_DIM;
        default: h = $urandom_range(MIN_DIM, 8);
      endcase
      write_config(w, h);
      run_frames(PHASE_ITEMS, ph);
    end

    // widest row, saturated from above; stop a little into row zero
    write_config(CFG_MAX, MIN_DIM);
    for (int i = 0; i < 40; i++) send_pixel(next_pixel(0, 0), i == 0);
    // narrow mid-frame with the column past the new width, then run the frame out
    write_config(MIN_DIM, MIN_DIM + 1);
    run_frames(0, 0);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_prewitt_edge_magnitude_core: PASS");
    end else begin
      $display("tb_prewitt_edge_magnitude_core: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pem_pkg.sv
hw/rtl/pem_window.sv
hw/rtl/pem_out_fifo.sv
hw/rtl/prewitt_edge_magnitude_core.sv
dv/tb_prewitt_edge_magnitude_core.sv
